/* hdl/ght_pkg.sv */
// Shared types, codes and sizes for the generational handle table.
`timescale 1ns / 1ps

package ght_pkg;

  localparam int unsigned SLOTS     = 16;
  localparam int unsigned GEN_BITS  = 32;
  localparam int unsigned SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W     = $clog2(SLOTS + 1);
  localparam int unsigned HIDX_W    = 32;  // handle index field
  localparam int unsigned HGEN_W    = 32;  // handle generation field
  localparam int unsigned RIDX_W    = 5;   // result index field
  localparam int unsigned LIVE_W    = 5;   // live count field

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_LOOKUP  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_BAD  = 2'd2
  } status_e;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [GEN_BITS-1:0] gen_t;
  typedef logic [CNT_W-1:0]    count_t;

  // update request to the slot tracker
  typedef struct packed {
    logic  set;
    logic  clr;
    slot_t slot;
  } slot_cmd_t;

  // tracker status
  typedef struct packed {
    logic   full;
    slot_t  free_slot;
    logic   query_used;
    count_t count;
  } slot_stat_t;

endpackage

/* hdl/ght_gen_mem.sv */
// Generation store: synchronous RAM with per-entry written bits, reads zero until written.
`timescale 1ns / 1ps

module ght_gen_mem
  import ght_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  re_i,
  input  slot_t raddr_i,
  input  logic  we_i,
  input  slot_t waddr_i,
  input  gen_t  wdata_i,
  output gen_t  rdata_o
);

  gen_t             mem [SLOTS];
  logic [SLOTS-1:0] written_q;
  gen_t             rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= written_q[raddr_i];
      end
    end
  end

  // never-written entries read as a generation of zero
  assign rdata_o = rvalid_q ? rdata_q : '0;

`ifndef SYNTH
  // a stored generation is never zero once an entry has been handed out
  a_wdata_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_i |-> (wdata_i != '0))
    else $error("zero generation written");
`endif

endmodule

/* hdl/ght_slot_track.sv */
// Used flags, lowest-free-slot search and live slot count.
`timescale 1ns / 1ps

module ght_slot_track
  import ght_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  slot_cmd_t  cmd_i,
  input  slot_t      query_i,
  output slot_stat_t stat_o
);

  logic [SLOTS-1:0] used_q, used_d;
  count_t           count_q, count_d;
  slot_t            free_slot;

  always_comb begin
    free_slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!used_q[s]) begin
        free_slot = slot_t'(s);
      end
    end
  end

  always_comb begin
    used_d  = used_q;
    count_d = count_q;
    if (cmd_i.set && !used_q[cmd_i.slot]) begin
      used_d[cmd_i.slot] = 1'b1;
      count_d            = count_q + 1'b1;
    end else if (cmd_i.clr && used_q[cmd_i.slot]) begin
      used_d[cmd_i.slot] = 1'b0;
      count_d            = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      count_q <= '0;
    end else begin
      used_q  <= used_d;
      count_q <= count_d;
    end
  end

  assign stat_o.full       = &used_q;
  assign stat_o.free_slot  = free_slot;
  assign stat_o.query_used = used_q[query_i];
  assign stat_o.count      = count_q;

`ifndef SYNTH
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == int'(count_q))
    else $error("live count out of step with used flags");

  a_set_clr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.set && cmd_i.clr))
    else $error("set and clear in one cycle");
`endif

endmodule

/* hdl/generational_handle_table.sv */
// Top level: generational handle table with a read-modify-write per transaction.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: action; tdata: index, generation
// m_axis    out  m_axis_tvalid/m_axis_tready   tuser: status; tdata: index, gen, live
//
// Each transaction is a read-modify-write: the accept edge launches the generation
// RAM read, and the commit edge writes back and loads the output register.
// A new transaction is not accepted until the previous one has written back.
// Reset clears the used flags, the live count and the RAM written bits; the RAM
// is usable right after reset. A stalled output holds the write-back stage, and
// input is taken while a finished result still waits in the output register.

module generational_handle_table
  import ght_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] handle_index, [63:32] handle_generation
  input  logic [1:0]  s_axis_tuser,  // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [4:0] result_index, [36:5] result_generation,
                                     // [41:37] slots_in_use, [47:42] zero
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WB   = 2'b10
  } state_e;

  state_e state_q, state_d;

  // input unpacking
  logic [HIDX_W-1:0] in_hidx;
  logic [HGEN_W-1:0] in_hgen;
  logic              in_idx_ok;
  slot_t             in_slot;
  logic              accept;

  // captured request
  logic [1:0]        req_act_q;
  logic              req_idx_ok_q;
  slot_t             req_slot_q;
  logic [RIDX_W-1:0] req_ridx_q;
  logic [HGEN_W-1:0] req_hgen_q;

  // output register
  logic              m_valid_q;
  status_e           m_status_q, m_status_d;
  logic [RIDX_W-1:0] m_ridx_q, m_ridx_d;
  logic [HGEN_W-1:0] m_rgen_q, m_rgen_d;
  logic [LIVE_W-1:0] m_live_q, m_live_d;

  // store interfaces
  slot_stat_t stat;
  slot_cmd_t  cmd;
  gen_t       gen_rd;
  gen_t       gen_inc;
  slot_t      rd_addr;
  logic       commit;
  logic       mem_we;
  count_t     live_after;

  assign in_hidx   = s_axis_tdata[31:0];
  assign in_hgen   = s_axis_tdata[63:32];
  assign in_idx_ok = (in_hidx != '0) && (in_hidx <= HIDX_W'(SLOTS));
  assign in_slot   = slot_t'(in_hidx - 1'b1);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // allocate reads the lowest free slot, the others the slot the handle names
  assign rd_addr = (s_axis_tuser == ACT_ALLOC) ? stat.free_slot : in_slot;

  // write back once the output register has room
  assign commit = (state_q == ST_WB) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_WB;
      ST_WB:   if (commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // next generation, wrapping past zero to one
  always_comb begin
    gen_inc = gen_rd + 1'b1;
    if (gen_inc == '0) begin
      gen_inc = gen_t'(1);
    end
  end

  // result and store updates of the write-back stage
  always_comb begin
    m_status_d = STS_BAD;
    m_ridx_d   = '0;
    m_rgen_d   = '0;
    live_after = stat.count;
    cmd.set    = 1'b0;
    cmd.clr    = 1'b0;
    cmd.slot   = req_slot_q;
    mem_we     = 1'b0;
    case (req_act_q)
      ACT_ALLOC: begin
        if (stat.full) begin
          m_status_d = STS_FULL;
        end else begin
          m_status_d = STS_OK;
          m_ridx_d   = RIDX_W'(32'(req_slot_q) + 32'd1);
          m_rgen_d   = HGEN_W'(gen_inc);
          live_after = stat.count + 1'b1;
          cmd.set    = commit;
          mem_we     = commit;
        end
      end
      ACT_RELEASE: begin
        if (req_idx_ok_q) begin
          m_status_d = STS_OK;
          m_ridx_d   = req_ridx_q;
          m_rgen_d   = HGEN_W'(gen_rd);
          if (stat.query_used) begin
            live_after = stat.count - 1'b1;
          end
          cmd.clr = commit;
        end
      end
      ACT_LOOKUP: begin
        // generation bits above the stored width never match
        if (req_idx_ok_q && (req_hgen_q != '0) && stat.query_used &&
            (HGEN_W'(gen_rd) == req_hgen_q)) begin
          m_status_d = STS_OK;
          m_ridx_d   = req_ridx_q;
          m_rgen_d   = HGEN_W'(gen_rd);
        end
      end
      default: begin
        m_status_d = STS_BAD;
      end
    endcase
    m_live_d = LIVE_W'(live_after);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_act_q    <= s_axis_tuser;
      req_idx_ok_q <= in_idx_ok;
      req_slot_q   <= (s_axis_tuser == ACT_ALLOC) ? stat.free_slot : in_slot;
      req_ridx_q   <= RIDX_W'(in_hidx);
      req_hgen_q   <= in_hgen;
    end
    if (commit) begin
      m_status_q <= m_status_d;
      m_ridx_q   <= m_ridx_d;
      m_rgen_q   <= m_rgen_d;
      m_live_q   <= m_live_d;
    end
  end

  ght_gen_mem u_gen_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .we_i    (mem_we),
    .waddr_i (req_slot_q),
    .wdata_i (gen_inc),
    .rdata_o (gen_rd)
  );

  ght_slot_track u_slot_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .query_i (req_slot_q),
    .stat_o  (stat)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {6'd0, m_live_q, m_rgen_q, m_ridx_q};

`ifndef SYNTH
  a_accept_to_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_WB))
    else $error("accepted transaction did not enter write-back");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> m_axis_tvalid)
    else $error("write-back produced no result");

  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (m_status_d == STS_OK)) |-> (m_ridx_d != '0))
    else $error("successful result with zero index");
`endif

endmodule

/* dv/generational_handle_table_test.sv */
// Self-checking stream testbench for the generational handle table: directed table, then random traffic.
`timescale 1ns / 1ps

module generational_handle_table_test;
  import ght_pkg::*;

  localparam logic [1:0] ACT_UNUSED   = 2'd3;  // spare action code, answered as bad
  localparam int         RANDOM_ITEMS = 850;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         IDLE_PCT     = 18;
  localparam int         CALM_FROM    = 1200;  // cycle window with no idling on either side
  localparam int         CALM_TO      = 2400;
  localparam int         DRAIN_CYCLES = 8;

  typedef struct packed {
    status_e     sts;
    logic [4:0]  idx;
    logic [31:0] gen;
    logic [4:0]  live;
  } handle_result_t;

  typedef struct {
    logic [1:0]     act;
    logic [31:0]    idx;
    logic [31:0]    gen;
    int             reps;
    bit             typed;   // exp is used instead of the predictor output
    handle_result_t exp;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  generational_handle_table u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the slot table.
  logic           slot_live [SLOTS];
  gen_t           slot_gen  [SLOTS];
  logic [4:0]     live_total;

  handle_result_t pending_results[$];
  int             mismatch_count = 0;
  int             cycle_count    = 0;
  bit             row_typed      = 1'b0;
  handle_result_t row_exp;
  stim_row_t      directed_rows[21];

  function automatic handle_result_t apply_handle_op(input logic [1:0] act,
                                                     input logic [31:0] idx,
                                                     input logic [31:0] gen);
    handle_result_t r;
    int             s;
    bit             found;
    gen_t           g;
    r     = '{STS_BAD, 5'd0, 32'd0, 5'd0};
    found = 1'b0;
    if (act == ACT_ALLOC) begin
      r.sts = STS_FULL;
      for (s = 0; s < SLOTS; s++) begin
        if (!found && !slot_live[s]) begin
          found = 1'b1;
          g = slot_gen[s] + 1'b1;
          if (g == '0) g = 1;  // generation skips zero on wrap
          slot_gen[s]  = g;
          slot_live[s] = 1'b1;
          live_total   = live_total + 1'b1;
          r.sts = STS_OK;
          r.idx = 5'(s + 1);
          r.gen = g;
        end
      end
    end else if ((act == ACT_RELEASE || act == ACT_LOOKUP) && idx != 0 && idx <= SLOTS) begin
      s = idx - 1;
      if (act == ACT_RELEASE) begin
        // freeing an already free slot still succeeds
        if (slot_live[s]) begin
          slot_live[s] = 1'b0;
          live_total   = live_total - 1'b1;
        end
        r.sts = STS_OK;
        r.idx = idx[4:0];
        r.gen = slot_gen[s];
      end else if (gen != 0 && slot_live[s] && slot_gen[s] == gen) begin
        r.sts = STS_OK;
        r.idx = idx[4:0];
        r.gen = slot_gen[s];
      end
    end
    r.live = live_total;
    return r;
  endfunction

  function automatic bit idle_roll();
    if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  // Sender: called at a falling edge, returns at the falling edge after acceptance.
  task automatic send_item(input logic [1:0] act, input logic [31:0] idx,
                           input logic [31:0] gen, input bit typed,
                           input handle_result_t exp);
    while (idle_roll()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    row_typed = typed;
    row_exp   = exp;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {gen, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= !idle_roll();
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("generational_handle_table regression: fail");
      $finish;
    end
  end

  // Scoreboard: predict on input acceptance, check on output acceptance.
  always @(posedge clk_i) begin
    handle_result_t want;
    handle_result_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{status_e'(m_axis_tuser), m_axis_tdata[4:0], m_axis_tdata[36:5],
                m_axis_tdata[41:37]};
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result sts=%0d idx=%0d gen=%0h live=%0d", $time,
                   got.sts, got.idx, got.gen, got.live);
        end else begin
          want = pending_results.pop_front();
          if (got.sts !== want.sts || got.idx !== want.idx ||
              got.gen !== want.gen || got.live !== want.live) begin
            mismatch_count++;
            $display("%0t: mismatch expected sts=%0d idx=%0d gen=%0h live=%0d, actual sts=%0d idx=%0d gen=%0h live=%0d",
                     $time, want.sts, want.idx, want.gen, want.live,
                     got.sts, got.idx, got.gen, got.live);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = apply_handle_op(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
        if (row_typed) want = row_exp;
        pending_results.push_back(want);
      end
    end
  end

  initial begin
    int             i;
    int             k;
    int             n;
    int             roll;
    int             alloc_bias;
    int             s;
    logic [1:0]     act;
    logic [31:0]    idx;
    logic [31:0]    gen;
    handle_result_t none;

    none = '{STS_BAD, 5'd0, 32'd0, 5'd0};
    for (i = 0; i < SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_gen[i]  = '0;
    end
    live_total = '0;

    // From reset: bad handles, freeing a free slot, fill to full, stale reuse.
    directed_rows[0]  = '{ACT_LOOKUP,  32'd1,        32'd1,        1,  1'b1, none};
    directed_rows[1]  = '{ACT_RELEASE, 32'd0,        32'd0,        1,  1'b1, none};
    directed_rows[2]  = '{ACT_RELEASE, 32'd17,       32'd0,        1,  1'b1, none};
    directed_rows[3]  = '{ACT_RELEASE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1,  1'b1, none};
    directed_rows[4]  = '{ACT_UNUSED,  32'd1,        32'd1,        1,  1'b1, none};
    directed_rows[5]  = '{ACT_RELEASE, 32'd1,        32'd0,        1,  1'b1,
                          '{STS_OK, 5'd1, 32'd0, 5'd0}};
    directed_rows[6]  = '{ACT_ALLOC,   32'hFFFFFFFF, 32'hFFFFFFFF, 1,  1'b1,
                          '{STS_OK, 5'd1, 32'd1, 5'd1}};
    directed_rows[7]  = '{ACT_LOOKUP,  32'd1,        32'd1,        1,  1'b1,
                          '{STS_OK, 5'd1, 32'd1, 5'd1}};
    directed_rows[8]  = '{ACT_LOOKUP,  32'd1,        32'd0,        1,  1'b1,
                          '{STS_BAD, 5'd0, 32'd0, 5'd1}};
    directed_rows[9]  = '{ACT_LOOKUP,  32'd1,        32'hFFFFFFFF, 1,  1'b1,
                          '{STS_BAD, 5'd0, 32'd0, 5'd1}};
    directed_rows[10] = '{ACT_LOOKUP,  32'd0,        32'd1,        1,  1'b1,
                          '{STS_BAD, 5'd0, 32'd0, 5'd1}};
    directed_rows[11] = '{ACT_LOOKUP,  32'd17,       32'd1,        1,  1'b1,
                          '{STS_BAD, 5'd0, 32'd0, 5'd1}};
    directed_rows[12] = '{ACT_ALLOC,   32'd0,        32'd0,        15, 1'b0, none};
    directed_rows[13] = '{ACT_ALLOC,   32'd0,        32'd0,        1,  1'b1,
                          '{STS_FULL, 5'd0, 32'd0, 5'd16}};
    directed_rows[14] = '{ACT_LOOKUP,  32'd16,       32'd1,        1,  1'b1,
                          '{STS_OK, 5'd16, 32'd1, 5'd16}};
    directed_rows[15] = '{ACT_RELEASE, 32'd16,       32'd0,        1,  1'b1,
                          '{STS_OK, 5'd16, 32'd1, 5'd15}};
    directed_rows[16] = '{ACT_LOOKUP,  32'd16,       32'd1,        1,  1'b1,
                          '{STS_BAD, 5'd0, 32'd0, 5'd15}};
    directed_rows[17] = '{ACT_ALLOC,   32'd0,        32'd0,        1,  1'b1,
                          '{STS_OK, 5'd16, 32'd2, 5'd16}};
    directed_rows[18] = '{ACT_LOOKUP,  32'd16,       32'd1,        1,  1'b1,
                          '{STS_BAD, 5'd0, 32'd0, 5'd16}};
    directed_rows[19] = '{ACT_LOOKUP,  32'd16,       32'd2,        1,  1'b0, none};
    directed_rows[20] = '{ACT_UNUSED,  32'hFFFFFFFF, 32'hFFFFFFFF, 1,  1'b1,
                          '{STS_BAD, 5'd0, 32'd0, 5'd16}};

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_ALLOC;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (i = 0; i < $size(directed_rows); i++) begin
      for (k = 0; k < directed_rows[i].reps; k++) begin
        send_item(directed_rows[i].act, directed_rows[i].idx, directed_rows[i].gen,
                  directed_rows[i].typed, directed_rows[i].exp);
      end
    end

    // Random traffic: mostly well-formed allocate, release and lookup operations, the rest noise.
    alloc_bias = 50;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 80 == 0) begin
        case ($urandom_range(2))
          0:       alloc_bias = 20;
          1:       alloc_bias = 50;
          default: alloc_bias = 80;
        endcase
      end
      idx  = $urandom;
      gen  = $urandom;
      roll = $urandom_range(99);
      if (roll < 12) begin
        act = 2'($urandom_range(3));
        if ($urandom_range(1)) idx = $urandom_range(20);
        if ($urandom_range(3) == 0) gen = $urandom_range(3);
      end else begin
        roll = $urandom_range(99);
        s    = $urandom_range(SLOTS - 1);
        if (roll < alloc_bias) begin
          act = ACT_ALLOC;
        end else if (roll < alloc_bias + (100 - alloc_bias) / 2) begin
          act = ACT_RELEASE;
          idx = s + 1;
        end else begin
          act = ACT_LOOKUP;
          idx = s + 1;
          roll = $urandom_range(99);
          if (roll < 70)      gen = slot_gen[s];
          else if (roll < 85) gen = slot_gen[s] - 1'b1;  // stale handle
        end
      end
      send_item(act, idx, gen, 1'b0, none);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("generational_handle_table regression: pass");
    end else begin
      $display("generational_handle_table regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/ght_pkg.sv
hdl/ght_gen_mem.sv
hdl/ght_slot_track.sv
hdl/generational_handle_table.sv
dv/generational_handle_table_test.sv
